[hw/rtl/b2d_pkg.sv]
package b2d_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int INPUT_WIDTH = 32;
   localparam int CHAR_WIDTH  = 6;
   localparam int DIGITS      = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int COUNT_WIDTH = $clog2(VALUE_BITS);
   localparam int DIGIT_INDEX_WIDTH = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   localparam logic [CHAR_WIDTH-1:0] ASCII_ZERO = CHAR_WIDTH'(48);

   typedef logic [3:0]            bcd_type;
   typedef logic [VALUE_BITS-1:0] value_type;

   typedef struct packed {
      logic clear;
      logic shift_bit;
      logic shift_digit;
   } cell_ctrl_type;

endpackage

[hw/rtl/b2d_digit_cell.sv]
module b2d_digit_cell (
   input  logic                  clock,
   input  b2d_pkg::cell_ctrl_type ctrl,
   input  logic                  carry_bit,
   input  b2d_pkg::bcd_type      lower_digit,
   output logic                  carry_out,
   output b2d_pkg::bcd_type      digit
);
   import b2d_pkg::*;

   bcd_type digit_ff;
   bcd_type digit_in;
   bcd_type adjusted;

   // add-3 correction before the shift
   assign adjusted  = (digit_ff >= 4'd5) ? bcd_type'(digit_ff + 4'd3) : digit_ff;
   assign carry_out = adjusted[3];
   assign digit     = digit_ff;

   always_comb begin
      priority if (ctrl.clear) begin
         digit_in = '0;
      end else if (ctrl.shift_bit) begin
         digit_in = {adjusted[2:0], carry_bit};
      end else if (ctrl.shift_digit) begin
         digit_in = lower_digit;
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

endmodule

[hw/rtl/binary_to_decimal_ascii.sv]
// Converts one unsigned 32-bit word on req_ into its decimal digits as ASCII
// characters on rsp_, most significant digit first, one rsp_ word per digit,
// leading zeros dropped (zero gives a single '0'); rsp_last_digit marks the
// final digit. A row of ten BCD digit cells runs a shift-and-add-3 conversion,
// one input bit per cycle, then the row shifts one digit per cycle toward the
// top cell, which feeds the output register, while rsp_ready allows. One word
// is converted at a time: the block accepts it, converts it and then walks the
// digit row (leading zeros skipped without output, digits sent as rsp_ready
// allows). A new word is taken as soon as the last digit sits in the output
// register.
module binary_to_decimal_ascii (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [b2d_pkg::INPUT_WIDTH-1:0]     req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [b2d_pkg::CHAR_WIDTH-1:0]      rsp_digit_char,
   output logic                                rsp_last_digit
);
   import b2d_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_CONV = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]                   state_ff, state_in;
   value_type                    value_ff, value_in;
   logic [COUNT_WIDTH-1:0]       count_ff, count_in;
   logic [DIGIT_INDEX_WIDTH-1:0] remain_ff, remain_in;
   logic                         started_ff, started_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [CHAR_WIDTH-1:0]        rsp_char_ff, rsp_char_in;
   logic                         rsp_last_ff, rsp_last_in;

   cell_ctrl_type ctrl;
   bcd_type       cell_digit [DIGITS];
   logic          cell_carry [DIGITS];
   bcd_type       top_digit;
   logic          req_accept;
   logic          is_last;
   logic          skip;
   logic          emit_load;

   assign req_ready      = (state_ff == ST_IDLE);
   assign req_accept     = req_valid && req_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_char_ff;
   assign rsp_last_digit = rsp_last_ff;

   assign top_digit = cell_digit[DIGITS-1];
   assign is_last   = (remain_ff == '0);
   assign skip      = (state_ff == ST_EMIT) && (top_digit == '0) && !started_ff && !is_last;
   assign emit_load = (state_ff == ST_EMIT) && !skip && (!rsp_valid_ff || rsp_ready);

   assign ctrl.clear       = req_accept;
   assign ctrl.shift_bit   = (state_ff == ST_CONV);
   assign ctrl.shift_digit = skip || emit_load;

   for (genvar i = 0; i < DIGITS; i++) begin : g_cell
      if (i == 0) begin : g_low
         b2d_digit_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .carry_bit  (value_ff[VALUE_BITS-1]),
            .lower_digit('0),
            .carry_out  (cell_carry[i]),
            .digit      (cell_digit[i])
         );
      end else begin : g_up
         b2d_digit_cell u_cell (
            .clock      (clock),
            .ctrl       (ctrl),
            .carry_bit  (cell_carry[i-1]),
            .lower_digit(cell_digit[i-1]),
            .carry_out  (cell_carry[i]),
            .digit      (cell_digit[i])
         );
      end
   end

   always_comb begin
      state_in     = state_ff;
      value_in     = value_ff;
      count_in     = count_ff;
      remain_in    = remain_ff;
      started_in   = started_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               value_in = value_type'(req_value);
               count_in = '0;
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            value_in = value_ff << 1;
            count_in = COUNT_WIDTH'(count_ff + 1'b1);
            if (count_ff == COUNT_WIDTH'(VALUE_BITS - 1)) begin
               remain_in  = DIGIT_INDEX_WIDTH'(DIGITS - 1);
               started_in = 1'b0;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (skip) begin
               remain_in = DIGIT_INDEX_WIDTH'(remain_ff - 1'b1);
            end else if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CHAR_WIDTH'(ASCII_ZERO + CHAR_WIDTH'(top_digit));
               rsp_last_in  = is_last;
               started_in   = 1'b1;
               remain_in    = DIGIT_INDEX_WIDTH'(remain_ff - 1'b1);
               if (is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         count_ff     <= '0;
         remain_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         started_ff   <= started_in;
         count_ff     <= count_in;
         remain_ff    <= remain_in;
      end
      value_ff    <= value_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   a_accept_starts_conv: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff == ST_CONV) && (count_ff == '0))
      else $error("conversion did not start after accept");

   a_conv_ends_in_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) && (count_ff == COUNT_WIDTH'(VALUE_BITS - 1))
      |=> (state_ff == ST_EMIT) && !started_ff)
      else $error("conversion length wrong");

   a_no_skip_after_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT) && started_ff |-> !skip)
      else $error("inner zero digit dropped");

   a_last_returns_idle: assert property (@(posedge clock) disable iff (reset)
      emit_load && is_last |=> (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff)
      else $error("final digit did not end the run");

   a_char_is_digit: assert property (@(posedge clock) disable iff (reset)
      emit_load |-> (top_digit <= 4'd9))
      else $error("digit cell left BCD range");

   a_no_row_overflow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> !cell_carry[DIGITS-1])
      else $error("digit row overflowed");

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps

module testbench;
   import b2d_pkg::*;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] digit_char;
      logic                  last_digit;
   } digit_word_type;

   localparam int RANDOM_VALUES = 400;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [INPUT_WIDTH-1:0] req_value = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [CHAR_WIDTH-1:0]  rsp_digit_char;
   logic                   rsp_last_digit;

   logic [INPUT_WIDTH-1:0] pending_values[$];
   digit_word_type         expected_digits[$];

   int unsigned mismatch_count   = 0;
   int unsigned values_sent      = 0;
   int unsigned zero_values      = 0;
   int unsigned ten_digit_values = 0;
   int unsigned digits_checked   = 0;
   int unsigned send_gap         = 0;
   int unsigned recv_stall       = 0;

   binary_to_decimal_ascii DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last_digit (rsp_last_digit)
   );

   always #10 clock = ~clock;

   // decimal digits, most significant first, appended to the expected store
   function automatic int unsigned predict_digits(input logic [INPUT_WIDTH-1:0] value);
      logic [63:0]    rest;
      logic [3:0]     reversed[$];
      digit_word_type word;
      rest = 64'(value) & ({64{1'b1}} >> (64 - VALUE_BITS));
      do begin
         reversed.push_back(4'(rest % 64'd10));
         rest = rest / 64'd10;
      end while (rest != 0);
      for (int k = reversed.size() - 1; k >= 0; k--) begin
         word.digit_char = ASCII_ZERO + CHAR_WIDTH'(reversed[k]);
         word.last_digit = (k == 0);
         expected_digits.push_back(word);
      end
      return reversed.size();
   endfunction

   function automatic bit calm_phase();
      return ((values_sent / 50) % 4) == 2;
   endfunction

   function automatic int unsigned pick_gap(input bit calm);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (calm || roll < 55)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 60);
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40)
         $display("%0t ns mismatch: %s", $time, what);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_ready !== 1'b1)) begin
         if (req_valid && req_ready === 1'b1) begin
            int unsigned count;
            count = predict_digits(req_value);
            values_sent++;
            if (req_value == 0)
               zero_values++;
            if (count == 10)
               ten_digit_values++;
            send_gap = pick_gap(calm_phase());
         end
         if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (pending_values.size() != 0) begin
            req_valid <= 1'b1;
            req_value <= pending_values.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            digit_word_type want;
            if (expected_digits.size() == 0) begin
               report_mismatch($sformatf("unexpected digit word: char %0d last %b",
                                         rsp_digit_char, rsp_last_digit));
            end else begin
               want = expected_digits.pop_front();
               digits_checked++;
               if (rsp_digit_char !== want.digit_char)
                  report_mismatch($sformatf("digit_char %0d, expected %0d",
                                            rsp_digit_char, want.digit_char));
               if (rsp_last_digit !== want.last_digit)
                  report_mismatch($sformatf("last_digit %b, expected %b",
                                            rsp_last_digit, want.last_digit));
            end
         end
         if (recv_stall > 0) begin
            recv_stall--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if (!calm_phase() && $urandom_range(0, 5) == 0)
               recv_stall = pick_gap(1'b0);
         end
      end
   end

   initial begin
      logic [INPUT_WIDTH-1:0] value;
      int unsigned            bits;
      pending_values = '{32'd0, 32'd1, 32'd9, 32'd10, 32'd99, 32'd100, 32'd999,
                         32'd1000, 32'd9999, 32'd10000, 32'd99999, 32'd100000,
                         32'd999999, 32'd1000000, 32'd9999999, 32'd10000000,
                         32'd99999999, 32'd100000000, 32'd999999999,
                         32'd1000000000, 32'hFFFF_FFFF, 32'hFFFF_FFFE,
                         32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555};
      for (int i = 0; i < RANDOM_VALUES; i++) begin
         bits  = $urandom_range(1, INPUT_WIDTH);
         value = $urandom;
         if (bits < INPUT_WIDTH)
            value = value & ((32'd1 << bits) - 32'd1);
         if ($urandom_range(0, 19) == 0)
            value = '0;
         pending_values.push_back(value);
      end

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      while (pending_values.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_digits.size() != 0)
         @(posedge clock);
      repeat (60) @(posedge clock);

      $display("converted %0d values (%0d zero, %0d with ten digits), %0d digit words checked",
               values_sent, zero_values, ten_digit_values, digits_checked);
      $display("sender gaps and receiver stalls random, with stretches of full rate");
      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   initial begin
      #50_000_000;
      $display("timeout: %0d values sent, %0d digit words still expected",
               values_sent, expected_digits.size());
      $display("== FAIL ==");
      $finish;
   end

endmodule
